@@ design/bis_pkg.sv @@
// ----------------------------------------------------------------------------
// Bounded integer set table - shared package
// Field widths, opcodes, controller states and the command/status bundles
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package bis_pkg;

   localparam int DEFAULT_CAPACITY = 128;

   localparam int OPCODE_W    = 2;
   localparam int VALUE_W     = 32;
   localparam int COUNT_W     = 8;
   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 16;

   localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST_RD,
      ST_MOVE,
      ST_INSERT,
      ST_FINISH
   } bis_state_type;

   typedef struct packed {
      logic start;    // latch the request beat, restart the scan
      logic scan;     // one scan step
      logic last_rd;  // read the last occupied entry
      logic move;     // write last entry into the hit slot, count down
      logic insert;   // append value or flag full
      logic load;     // load the response register
   } bis_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic found;
      logic is_insert;
      logic is_remove;
      logic rsp_free;
   } bis_status_type;

endpackage

@@ design/bis_ctrl.sv @@
// ----------------------------------------------------------------------------
// Bounded integer set table - controller
// Sequences one operation: scan, optional move or append, response load.
// ----------------------------------------------------------------------------
module bis_ctrl
   import bis_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  bis_status_type status,
   output bis_cmd_type    cmd
);

   bis_state_type state_ff;
   bis_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               if (status.is_remove && status.found) begin
                  state_in = ST_LAST_RD;
               end else if (status.is_insert && !status.found) begin
                  state_in = ST_INSERT;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_LAST_RD: begin
            cmd.last_rd = 1'b1;
            state_in    = ST_MOVE;
         end
         ST_MOVE: begin
            cmd.move = 1'b1;
            state_in = ST_FINISH;
         end
         ST_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ design/bis_dpath.sv @@
// ----------------------------------------------------------------------------
// Bounded integer set table - datapath
// Entry memory with registered read, element count, scan pointer and
// the response register.
// ----------------------------------------------------------------------------
module bis_dpath
   import bis_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  bis_cmd_type            cmd,
   output bis_status_type         status,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = $clog2(CAPACITY);

   logic [VALUE_W-1:0] entries_ff [CAPACITY];
   logic [VALUE_W-1:0] rdata_ff;

   logic [CNT_W-1:0]    cnt_ff,       cnt_in;
   logic [CNT_W-1:0]    scan_idx_ff,  scan_idx_in;
   logic                pend_ff,      pend_in;
   logic [ADDR_W-1:0]   pend_idx_ff,  pend_idx_in;
   logic [OPCODE_W-1:0] op_ff,        op_in;
   logic [VALUE_W-1:0]  value_ff,     value_in;
   logic                found_ff,     found_in;
   logic [ADDR_W-1:0]   slot_ff,      slot_in;
   logic                full_err_ff,  full_err_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in;
   logic                rsp_full_ff,  rsp_full_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic               wr_en;
   logic [ADDR_W-1:0]  waddr;
   logic [VALUE_W-1:0] wdata;
   logic [ADDR_W-1:0]  raddr;
   logic [CNT_W-1:0]   last_idx;
   logic               exhausted;
   logic               hit;

   // entry memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[waddr] <= wdata;
      end
      rdata_ff <= entries_ff[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff  <= scan_idx_in;
      pend_idx_ff  <= pend_idx_in;
      op_ff        <= op_in;
      value_ff     <= value_in;
      found_ff     <= found_in;
      slot_ff      <= slot_in;
      full_err_ff  <= full_err_in;
      rsp_found_ff <= rsp_found_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign last_idx  = cnt_ff - CNT_W'(1);
   assign exhausted = (scan_idx_ff == cnt_ff);
   // compare uses the registered read data, so it checks the entry addressed in the previous scan step
   assign hit       = cmd.scan && pend_ff && (rdata_ff == value_ff);

   always_comb begin
      cnt_in       = cnt_ff;
      scan_idx_in  = scan_idx_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      op_in        = op_ff;
      value_in     = value_ff;
      found_in     = found_ff;
      slot_in      = slot_ff;
      full_err_in  = full_err_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_count_in = rsp_count_ff;
      wr_en        = 1'b0;
      waddr        = cnt_ff[ADDR_W-1:0];
      wdata        = value_ff;
      raddr        = scan_idx_ff[ADDR_W-1:0];

      if (cmd.start) begin
         op_in       = req_tuser[OPCODE_W-1:0];
         value_in    = req_tdata[VALUE_W-1:0];
         scan_idx_in = '0;
         found_in    = 1'b0;
         full_err_in = 1'b0;
      end

      if (cmd.scan) begin
         if (!exhausted) begin
            scan_idx_in = scan_idx_ff + CNT_W'(1);
            pend_in     = 1'b1;
            pend_idx_in = scan_idx_ff[ADDR_W-1:0];
         end
         if (hit) begin
            found_in = 1'b1;
            slot_in  = pend_idx_ff;
         end
      end

      if (cmd.last_rd) begin
         raddr = last_idx[ADDR_W-1:0];
      end

      if (cmd.move) begin
         wr_en  = 1'b1;
         waddr  = slot_ff;
         wdata  = rdata_ff;
         cnt_in = last_idx;
      end

      if (cmd.insert) begin
         if (cnt_ff == CNT_W'(CAPACITY)) begin
            full_err_in = 1'b1;
         end else begin
            wr_en  = 1'b1;
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = found_ff;
         rsp_full_in  = full_err_ff;
         rsp_count_in = COUNT_W'(cnt_ff);
      end
   end

   assign status.scan_done = hit || (exhausted && !pend_ff);
   assign status.found     = found_ff || hit;
   assign status.is_insert = (op_ff == OP_INSERT);
   assign status.is_remove = (op_ff == OP_REMOVE);
   assign status.rsp_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - COUNT_W - 2){1'b0}},
                        rsp_count_ff, rsp_full_ff, rsp_found_ff};

endmodule

@@ design/bounded_integer_set_table_core.sv @@
// ----------------------------------------------------------------------------
// Bounded integer set table - top level
// Holds up to CAPACITY distinct 32-bit integers; insert, remove and query.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel req_*: one beat per operation. req_tuser carries the
//   opcode (insert, remove, query; the spare code queries), req_tdata the
//   32-bit value. Response channel rsp_*: exactly one beat per request with
//   found, full_error and the element count (low 8 bits) after the op.
//   Every operation scans the occupied entries one per cycle through the
//   single read port of the entry memory, so an item takes longer the
//   more entries the set holds; a remove that hits adds a read of the
//   last entry and a move, an insert that misses adds an append. One item
//   is in flight at a time: a request beat is taken only in the idle state.
//   Reset empties the set at once; no clearing pass, entries are only read
//   below the count. The response sits in an output register: the next
//   request is taken while it waits, and a stalled receiver only holds up
//   the following result.
// ----------------------------------------------------------------------------
module bounded_integer_set_table_core
   import bis_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // [31:0] value
   input  logic [REQ_TUSER_W-1:0] req_tuser,  // [1:0] opcode
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata   // [0] found, [1] full_error, [9:2] count
);

   bis_cmd_type    cmd;
   bis_status_type status;

   bis_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bis_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ verif/set_table_checker.sv @@
// ----------------------------------------------------------------------------
// Bounded integer set table - channel checker
// Watches both stream channels, keeps its own copy of the set and counts every
// disagreeing field of a response beat, and every unexpected beat.
// ----------------------------------------------------------------------------
module set_table_checker
   import bis_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // [31:0] value
   input  logic [REQ_TUSER_W-1:0] req_tuser,  // [1:0] opcode
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,  // [0] found, [1] full_error, [9:2] count
   output int                     mismatches,
   output int                     pending,
   output int                     results_seen,
   output int                     full_errors_seen,
   output int                     hits_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic               found;
      logic               full_error;
      logic [COUNT_W-1:0] count;
   } set_outcome_type;

   logic signed [VALUE_W-1:0] members [CAPACITY];
   int                        member_count;
   set_outcome_type           expected_outcomes [$];

   // Linear search of the occupied slots, then the set update.
   function automatic set_outcome_type apply_set_op(logic [OPCODE_W-1:0] op,
                                                    logic signed [VALUE_W-1:0] value);
      set_outcome_type outcome;
      int              slot;
      int              idx;
      slot = -1;
      for (idx = 0; idx < member_count; idx++) begin
         if (slot < 0 && members[idx] == value) slot = idx;
      end
      outcome.found      = (slot >= 0);
      outcome.full_error = 1'b0;
      case (op)
         OP_INSERT: begin
            if (slot < 0) begin
               if (member_count >= CAPACITY) begin
                  outcome.full_error = 1'b1;
               end else begin
                  members[member_count] = value;
                  member_count++;
               end
            end
         end
         OP_REMOVE: begin
            // last occupied entry fills the hole
            if (slot >= 0) begin
               members[slot] = members[member_count-1];
               member_count--;
            end
         end
         default: begin
         end
      endcase
      outcome.count = COUNT_W'(member_count);
      return outcome;
   endfunction

   always @(posedge clock) begin
      set_outcome_type want;
      set_outcome_type got;
      if (reset) begin
         member_count = 0;
         expected_outcomes.delete();
         pending          = 0;
         mismatches       = 0;
         results_seen     = 0;
         full_errors_seen = 0;
         hits_seen        = 0;
      end else begin
         // a response can never belong to the request taken on this same edge
         if (rsp_tvalid && rsp_tready) begin
            got.found      = rsp_tdata[0];
            got.full_error = rsp_tdata[1];
            got.count      = rsp_tdata[9:2];
            results_seen++;
            if (got.full_error) full_errors_seen++;
            if (got.found) hits_seen++;
            if (expected_outcomes.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected response, got found=%0b full_error=%0b count=%0d",
                        $time, got.found, got.full_error, got.count);
            end else begin
               want = expected_outcomes.pop_front();
               if (got.found !== want.found) begin
                  mismatches++;
                  $display("%0t: found mismatch, expected %0b, got %0b",
                           $time, want.found, got.found);
               end
               if (got.full_error !== want.full_error) begin
                  mismatches++;
                  $display("%0t: full_error mismatch, expected %0b, got %0b",
                           $time, want.full_error, got.full_error);
               end
               if (got.count !== want.count) begin
                  mismatches++;
                  $display("%0t: count mismatch, expected %0d, got %0d",
                           $time, want.count, got.count);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_outcomes.push_back(apply_set_op(req_tuser, req_tdata));
         end
         pending = expected_outcomes.size();
      end
   end

   final begin
      if (expected_outcomes.size() != 0)
         $display("%0t: %0d responses still outstanding", $time, expected_outcomes.size());
   end

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// Bounded integer set table - testbench top
// Drives insert, remove and query beats through the core: a directed opening,
// then random traffic over a value pool that fills, churns and drains the set,
// with random idling on both channels. The checker scores every response.
// ----------------------------------------------------------------------------
module tb_top
   import bis_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SET_CAPACITY = DEFAULT_CAPACITY;
   localparam int POOL_SIZE    = 200;
   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;  // [31:0] value
   logic [REQ_TUSER_W-1:0] req_tuser;  // [1:0] opcode
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;  // [0] found, [1] full_error, [9:2] count

   int mismatches;
   int pending;
   int results_seen;
   int full_errors_seen;
   int hits_seen;

   bit tx_gaps   = 1'b0;
   bit rx_stalls = 1'b0;
   int ops_sent  = 0;
   int cycle_count = 0;

   logic [VALUE_W-1:0] value_pool [POOL_SIZE];
   logic [VALUE_W-1:0] stray_values [$];

   bounded_integer_set_table_core #(.CAPACITY(SET_CAPACITY)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   set_table_checker #(.CAPACITY(SET_CAPACITY)) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .mismatches       (mismatches),
      .pending          (pending),
      .results_seen     (results_seen),
      .full_errors_seen (full_errors_seen),
      .hits_seen        (hits_seen)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run timed out with %0d responses outstanding", $time, pending);
         $display("tb: failure");
         $finish;
      end
   end

   // Receiver: random stall bursts while enabled.
   initial begin
      int hold;
      hold = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(negedge clock);
         if (!rx_stalls) begin
            hold = 0;
            rsp_tready <= 1'b1;
         end else if (hold > 0) begin
            hold--;
         end else if ($urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            hold = $urandom_range(0, 15);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic bit in_pool(logic [VALUE_W-1:0] value);
      int idx;
      for (idx = 0; idx < POOL_SIZE; idx++) begin
         if (value_pool[idx] == value) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic [OPCODE_W-1:0] pick_op(int insert_pct, int remove_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < insert_pct) return OP_INSERT;
      if (roll < insert_pct + remove_pct) return OP_REMOVE;
      if (roll < 95) return OP_QUERY;
      return OP_SPARE;
   endfunction

   // Mostly pool values so that hits happen; now and then an arbitrary word.
   function automatic logic [VALUE_W-1:0] pick_value(int span);
      if ($urandom_range(0, 9) == 0) return $urandom();
      return value_pool[$urandom_range(0, span - 1)];
   endfunction

   // Called and returns at a falling edge; valid stays up for the next beat.
   task automatic send_op(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] value);
      if (tx_gaps && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom();
         req_tuser  <= REQ_TUSER_W'($urandom_range(0, 3));
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ops_sent++;
      if (op == OP_INSERT && !in_pool(value)) stray_values.push_back(value);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic random_ops(int n, int span, int insert_pct, int remove_pct);
      logic [OPCODE_W-1:0] op;
      repeat (n) begin
         op = pick_op(insert_pct, remove_pct);
         send_op(op, pick_value(span));
      end
   endtask

   initial begin
      int order [POOL_SIZE];
      int idx;
      int swap_idx;
      int tmp;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_QUERY;

      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7FFF_FFFF;
      value_pool[2] = 32'h0000_0000;
      value_pool[3] = 32'hFFFF_FFFF;
      value_pool[4] = 32'h0000_0001;
      value_pool[5] = 32'h8000_0001;
      for (idx = 6; idx < POOL_SIZE; idx++) value_pool[idx] = $urandom();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed opening on an empty set
      send_op(OP_QUERY,  32'h8000_0000);
      send_op(OP_REMOVE, 32'h7FFF_FFFF);   // remove from empty set
      send_op(OP_INSERT, 32'h8000_0000);
      send_op(OP_INSERT, 32'h7FFF_FFFF);
      send_op(OP_INSERT, 32'h0000_0000);
      send_op(OP_INSERT, 32'hFFFF_FFFF);
      send_op(OP_INSERT, 32'h7FFF_FFFF);   // already present
      send_op(OP_QUERY,  32'hFFFF_FFFF);
      send_op(OP_SPARE,  32'h0000_0000);   // spare code behaves as query
      send_op(OP_SPARE,  32'h1234_5678);
      send_op(OP_REMOVE, 32'h8000_0000);   // first slot, last entry moves in
      send_op(OP_QUERY,  32'hFFFF_FFFF);
      send_op(OP_REMOVE, 32'h8000_0000);   // now absent
      send_op(OP_REMOVE, 32'hFFFF_FFFF);
      send_op(OP_INSERT, 32'h5555_5555);
      send_op(OP_INSERT, 32'hAAAA_AAAA);
      send_op(OP_REMOVE, 32'hAAAA_AAAA);   // hit on the last entry itself
      send_op(OP_QUERY,  32'h7FFF_FFFF);
      send_op(OP_REMOVE, 32'h0000_0000);

      // light churn on a small working set
      tx_gaps   = 1'b1;
      rx_stalls = 1'b1;
      random_ops(400, 48, 45, 30);
      wait_drained();

      // fill past capacity: later inserts hit the full set
      for (idx = 0; idx < POOL_SIZE; idx++) send_op(OP_INSERT, value_pool[idx]);

      // churn around the full mark, with a stretch of unbroken traffic
      random_ops(250, POOL_SIZE, 50, 20);
      tx_gaps   = 1'b0;
      rx_stalls = 1'b0;
      random_ops(200, POOL_SIZE, 50, 20);
      tx_gaps   = 1'b1;
      rx_stalls = 1'b1;
      random_ops(250, POOL_SIZE, 50, 20);
      wait_drained();

      // drain everything in random order
      for (idx = 0; idx < POOL_SIZE; idx++) order[idx] = idx;
      for (idx = POOL_SIZE - 1; idx > 0; idx--) begin
         swap_idx = $urandom_range(0, idx);
         tmp = order[idx];
         order[idx] = order[swap_idx];
         order[swap_idx] = tmp;
      end
      for (idx = 0; idx < POOL_SIZE; idx++) begin
         send_op(OP_REMOVE, value_pool[order[idx]]);
         if ($urandom_range(0, 4) == 0) send_op(OP_QUERY, pick_value(POOL_SIZE));
      end
      while (stray_values.size() != 0) send_op(OP_REMOVE, stray_values.pop_front());

      // closing part without idling
      tx_gaps   = 1'b0;
      rx_stalls = 1'b0;
      random_ops(150, 16, 45, 30);

      wait_drained();
      repeat (SET_CAPACITY + 16) @(negedge clock);

      $display("tb: %0d set operations sent, %0d responses checked", ops_sent, results_seen);
      $display("tb: %0d hits on present values, %0d inserts refused on a full set",
               hits_seen, full_errors_seen);
      if (mismatches == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
